[design/pmq_pkg.sv]
// Shared constants and types for the pose to position and quaternion block.
package pmq_pkg;

   localparam int RotW   = 18;
   localparam int OffW   = 21;
   localparam int TrW    = 32;
   localparam int RadW   = 20;  // radicand range below 2^19, signed
   localparam int SqInW  = 36;  // clamped radicand shifted left by 16
   localparam int RootW  = 18;  // isqrt of a 36 bit value
   localparam int SqStep = 18;  // one result bit per step
   localparam int SumW   = 42;  // three 18x21 products summed

   localparam logic [1:0] CsrOffX = 2'd0;
   localparam logic [1:0] CsrOffY = 2'd1;
   localparam logic [1:0] CsrOffZ = 2'd2;

   localparam logic signed [OffW-1:0] OffXReset = 21'sd0;
   localparam logic signed [OffW-1:0] OffYReset = -21'sd6554;
   localparam logic signed [OffW-1:0] OffZReset = -21'sd13107;

   // State of one restoring square root carried between stages
   typedef struct packed {
      logic [SqInW-1:0] rem;
      logic [RootW-1:0] root;
      logic [SqInW-1:0] num;
   } sq_state_type;

endpackage

[design/pose_matrix_to_position_quaternion.sv]
// Top level: pose matrix to transformed position and quaternion.
//
//  channel | ports                          | direction
//  req     | req_valid req_stall r00..tz    | in, one pose per beat
//  rsp     | rsp_valid rsp_stall pos_*,quat_*| out, one result per beat
//  csr     | csr_write csr_index csr_data   | in, offset registers
//
// One beat enters every cycle unless rsp stalls. The path runs through
// the input register, the 18 stage square root (one root bit per stage)
// and the sign/halving stage. The position path is 3 stages, delayed
// to match. The whole pipeline advances together; a stall on rsp holds
// every stage, and req_stall follows rsp_stall while the output holds
// a beat. Reset clears valid bits and restores the offsets.
module pose_matrix_to_position_quaternion (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [17:0]  req_r00, req_r01, req_r02,
   input  logic [31:0]  req_tx,
   input  logic [17:0]  req_r10, req_r11, req_r12,
   input  logic [31:0]  req_ty,
   input  logic [17:0]  req_r20, req_r21, req_r22,
   input  logic [31:0]  req_tz,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_pos_x, rsp_pos_y, rsp_pos_z,
   output logic [16:0]  rsp_quat_w,
   output logic [17:0]  rsp_quat_x, rsp_quat_y, rsp_quat_z,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [20:0]  csr_data
);
   localparam int Lat = pmq_pkg::SqStep + 2;

   logic signed [20:0] off_x_ff, off_y_ff, off_z_ff;
   logic [Lat-1:0]     vld_ff;
   logic               enable;

   // Pipeline moves unless a finished beat waits at the output
   assign enable    = !(vld_ff[Lat-1] && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         off_x_ff <= pmq_pkg::OffXReset;
         off_y_ff <= pmq_pkg::OffYReset;
         off_z_ff <= pmq_pkg::OffZReset;
      end else begin
         if (enable) begin
            vld_ff <= {vld_ff[Lat-2:0], req_valid};
         end
         if (csr_write) begin
            unique case (csr_index)
               pmq_pkg::CsrOffX: off_x_ff <= csr_data;
               pmq_pkg::CsrOffY: off_y_ff <= csr_data;
               pmq_pkg::CsrOffZ: off_z_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Input register
   logic signed [17:0] r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic signed [17:0] r20_ff, r21_ff, r22_ff;
   logic signed [31:0] tx_ff, ty_ff, tz_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         r00_ff <= req_r00; r01_ff <= req_r01; r02_ff <= req_r02;
         r10_ff <= req_r10; r11_ff <= req_r11; r12_ff <= req_r12;
         r20_ff <= req_r20; r21_ff <= req_r21; r22_ff <= req_r22;
         tx_ff  <= req_tx;  ty_ff  <= req_ty;  tz_ff  <= req_tz;
      end
   end

   // Radicands and sign bits
   logic signed [19:0] rad_w, rad_x, rad_y, rad_z;
   logic signed [18:0] dx, dy, dz;
   logic [2:0]         neg_ff [pmq_pkg::SqStep];

   always_comb begin
      rad_w = 20'sd65536 + 20'(r00_ff) + 20'(r11_ff) + 20'(r22_ff);
      rad_x = 20'sd65536 + 20'(r00_ff) - 20'(r11_ff) - 20'(r22_ff);
      rad_y = 20'sd65536 - 20'(r00_ff) + 20'(r11_ff) - 20'(r22_ff);
      rad_z = 20'sd65536 - 20'(r00_ff) - 20'(r11_ff) + 20'(r22_ff);
      dx = 19'(r21_ff) - 19'(r12_ff);
      dy = 19'(r02_ff) - 19'(r20_ff);
      dz = 19'(r10_ff) - 19'(r01_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff[0] <= {dz[18], dy[18], dx[18]};
         for (int i = 1; i < pmq_pkg::SqStep; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   logic [17:0] rt_w, rt_x, rt_y, rt_z;

   pmq_sqrt u_sq_w (.clock(clock), .enable(enable), .radicand(rad_w), .root(rt_w));
   pmq_sqrt u_sq_x (.clock(clock), .enable(enable), .radicand(rad_x), .root(rt_x));
   pmq_sqrt u_sq_y (.clock(clock), .enable(enable), .radicand(rad_y), .root(rt_y));
   pmq_sqrt u_sq_z (.clock(clock), .enable(enable), .radicand(rad_z), .root(rt_z));

   logic signed [31:0] px, py, pz;

   pmq_position #(.Depth(pmq_pkg::SqStep)) u_px (
      .clock(clock), .enable(enable), .ra(r00_ff), .rb(r01_ff), .rc(r02_ff), .t(tx_ff),
      .off_x(off_x_ff), .off_y(off_y_ff), .off_z(off_z_ff), .pos(px));
   pmq_position #(.Depth(pmq_pkg::SqStep)) u_py (
      .clock(clock), .enable(enable), .ra(r10_ff), .rb(r11_ff), .rc(r12_ff), .t(ty_ff),
      .off_x(off_x_ff), .off_y(off_y_ff), .off_z(off_z_ff), .pos(py));
   pmq_position #(.Depth(pmq_pkg::SqStep)) u_pz (
      .clock(clock), .enable(enable), .ra(r20_ff), .rb(r21_ff), .rc(r22_ff), .t(tz_ff),
      .off_x(off_x_ff), .off_y(off_y_ff), .off_z(off_z_ff), .pos(pz));

   // Halve the roots, apply signs, register the output beat
   logic [16:0] hx, hy, hz;
   logic [2:0]  ng;

   always_comb begin
      hx = rt_x[17:1];
      hy = rt_y[17:1];
      hz = rt_z[17:1];
      ng = neg_ff[pmq_pkg::SqStep-1];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_pos_x  <= px;
         rsp_pos_y  <= py;
         rsp_pos_z  <= pz;
         rsp_quat_w <= rt_w[17:1];
         rsp_quat_x <= ng[0] ? 18'(-{1'b0, hx}) : {1'b0, hx};
         rsp_quat_y <= ng[1] ? 18'(-{1'b0, hy}) : {1'b0, hy};
         rsp_quat_z <= ng[2] ? 18'(-{1'b0, hz}) : {1'b0, hz};
      end
   end
endmodule

[design/pmq_sqrt_stage.sv]
// One bit step of the pipelined integer square root.
module pmq_sqrt_stage #(
   parameter int Step = 0
) (
   input  logic                  clock,
   input  logic                  enable,
   input  pmq_pkg::sq_state_type st_in,
   output pmq_pkg::sq_state_type st_ff
);
   localparam int Sh = 2 * (pmq_pkg::SqStep - 1 - Step);

   logic [pmq_pkg::SqInW-1:0]   rem_sh;
   logic [pmq_pkg::SqInW+1:0]   trial;
   logic [pmq_pkg::SqInW+1:0]   cand;
   pmq_pkg::sq_state_type       st_in_next;

   always_comb begin
      rem_sh = {st_in.rem[pmq_pkg::SqInW-3:0], st_in.num[Sh+1 -: 2]};
      cand   = {{(pmq_pkg::SqInW+2-pmq_pkg::RootW-2){1'b0}}, st_in.root, 2'b01};
      trial  = {2'b00, rem_sh} - cand;
      st_in_next.num = st_in.num;
      if (!trial[pmq_pkg::SqInW+1]) begin
         st_in_next.rem  = trial[pmq_pkg::SqInW-1:0];
         st_in_next.root = {st_in.root[pmq_pkg::RootW-2:0], 1'b1};
      end else begin
         st_in_next.rem  = rem_sh;
         st_in_next.root = {st_in.root[pmq_pkg::RootW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff <= st_in_next;
      end
   end
endmodule

[design/pmq_sqrt.sv]
// Pipelined square root: clamp, shift and one result bit per stage.
module pmq_sqrt (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [pmq_pkg::RadW-1:0]   radicand,
   output logic [pmq_pkg::RootW-1:0]         root
);
   pmq_pkg::sq_state_type st [pmq_pkg::SqStep+1];
   logic [pmq_pkg::SqInW-1:0] num;

   always_comb begin
      if (radicand[pmq_pkg::RadW-1]) begin
         num = '0;
      end else begin
         num = {radicand[pmq_pkg::SqInW-17:0], 16'd0};
      end
      st[0].rem  = '0;
      st[0].root = '0;
      st[0].num  = num;
   end

   for (genvar g = 0; g < pmq_pkg::SqStep; g++) begin : g_stage
      pmq_sqrt_stage #(.Step(g)) u_stage (
         .clock (clock),
         .enable(enable),
         .st_in (st[g]),
         .st_ff (st[g+1])
      );
   end

   assign root = st[pmq_pkg::SqStep].root;
endmodule

[design/pmq_position.sv]
// Position datapath: products, sum with rounding, translation add, saturation.
module pmq_position #(
   parameter int Depth = 18
) (
   input  logic                            clock,
   input  logic                            enable,
   input  logic signed [pmq_pkg::RotW-1:0] ra,
   input  logic signed [pmq_pkg::RotW-1:0] rb,
   input  logic signed [pmq_pkg::RotW-1:0] rc,
   input  logic signed [pmq_pkg::TrW-1:0]  t,
   input  logic signed [pmq_pkg::OffW-1:0] off_x,
   input  logic signed [pmq_pkg::OffW-1:0] off_y,
   input  logic signed [pmq_pkg::OffW-1:0] off_z,
   output logic signed [pmq_pkg::TrW-1:0]  pos
);
   localparam int PW = pmq_pkg::RotW + pmq_pkg::OffW;
   localparam int RW = pmq_pkg::SumW - 16;

   logic signed [PW-1:0]              pa_ff, pb_ff, pc_ff;
   logic signed [pmq_pkg::TrW-1:0]    t1_ff;
   logic signed [pmq_pkg::SumW-1:0]   sum_in;
   logic signed [RW-1:0]              rnd_ff;
   logic signed [pmq_pkg::TrW-1:0]    t2_ff;
   logic signed [pmq_pkg::TrW:0]      tot;
   logic signed [pmq_pkg::TrW-1:0]    sat_in;
   logic signed [pmq_pkg::TrW-1:0]    dly_ff [Depth-2];

   always_comb begin
      sum_in = pmq_pkg::SumW'(pa_ff) + pmq_pkg::SumW'(pb_ff) + pmq_pkg::SumW'(pc_ff)
               + pmq_pkg::SumW'(32768);
      tot = (pmq_pkg::TrW+1)'(rnd_ff) + (pmq_pkg::TrW+1)'(t2_ff);
      if (tot > 33'sd2147483647) begin
         sat_in = 32'sh7FFFFFFF;
      end else if (tot < -33'sd2147483648) begin
         sat_in = 32'sh80000000;
      end else begin
         sat_in = tot[pmq_pkg::TrW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pa_ff  <= PW'(ra) * PW'(off_x);
         pb_ff  <= PW'(rb) * PW'(off_y);
         pc_ff  <= PW'(rc) * PW'(off_z);
         t1_ff  <= t;
         rnd_ff <= sum_in[pmq_pkg::SumW-1:16];
         t2_ff  <= t1_ff;
         dly_ff[0] <= sat_in;
         for (int i = 1; i < Depth - 2; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign pos = dly_ff[Depth-3];
endmodule

[design/pmq_checker.sv]
// Port-level checks for the pose to position and quaternion block.
module pmq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_quat_w,
   input logic [17:0] rsp_quat_x
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_x))
      else $error("rsp beat changed while stalled");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a held rsp beat");

   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_w <= 17'd65536 + 17'd32768)
      else $error("quat_w out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid just after reset");
endmodule

bind pose_matrix_to_position_quaternion pmq_checker u_pmq_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_quat_w(rsp_quat_w),
   .rsp_quat_x(rsp_quat_x)
);

[tb/sv/pose_matrix_to_position_quaternion_tb.sv]
// Self-checking testbench for the pose to position and quaternion block.
module pose_matrix_to_position_quaternion_tb;

   // One pose as driven on the request channel
   typedef struct {
      logic signed [17:0] r [9];
      logic signed [31:0] t [3];
   } pose_type;

   // One expected result beat
   typedef struct {
      logic [31:0] pos [3];
      logic [16:0] qw;
      logic [17:0] qv [3];
   } pose_result_type;

   // Holds the offsets, predicts each result and compares arrivals in order
   class pose_scoreboard;
      logic signed [20:0] offset [3];
      pose_result_type    pending [$];
      int                 errors;
      int                 checked;

      function new();
         offset[0] = pmq_pkg::OffXReset;
         offset[1] = pmq_pkg::OffYReset;
         offset[2] = pmq_pkg::OffZReset;
         errors = 0;
         checked = 0;
      endfunction

      function void write_offset(logic [1:0] idx, logic [20:0] value);
         if (idx == pmq_pkg::CsrOffX) offset[0] = value;
         else if (idx == pmq_pkg::CsrOffY) offset[1] = value;
         else if (idx == pmq_pkg::CsrOffZ) offset[2] = value;
      endfunction

      function longint half_sqrt(longint radicand);
         longint unsigned n;
         longint unsigned root;
         longint unsigned b;
         if (radicand < 0) radicand = 0;
         n = radicand << 16;
         root = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= root + b) begin
               n = n - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return longint'(root >> 1);
      endfunction

      function void note_pose(pose_type p);
         pose_result_type res;
         longint rr [9];
         longint s, v, d, m;
         longint rad [4];
         for (int i = 0; i < 9; i++) rr[i] = p.r[i];
         for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int j = 0; j < 3; j++) s += rr[3*i+j] * longint'(offset[j]);
            // half-up rounding is floor of (s + half) / 2^16
            v = ((s + 32768) >>> 16) + longint'(p.t[i]);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            res.pos[i] = v[31:0];
         end
         rad[0] = 65536 + rr[0] + rr[4] + rr[8];
         rad[1] = 65536 + rr[0] - rr[4] - rr[8];
         rad[2] = 65536 - rr[0] + rr[4] - rr[8];
         rad[3] = 65536 - rr[0] - rr[4] + rr[8];
         m = half_sqrt(rad[0]);
         res.qw = m[16:0];
         for (int k = 0; k < 3; k++) begin
            case (k)
               0: d = rr[7] - rr[5];
               1: d = rr[2] - rr[6];
               default: d = rr[3] - rr[1];
            endcase
            m = half_sqrt(rad[k+1]);
            if (d < 0) m = -m;
            res.qv[k] = m[17:0];
         end
         pending.push_back(res);
      endfunction

      function void check_result(pose_result_type got);
         pose_result_type e;
         string axis [3];
         axis = '{"x", "y", "z"};
         checked++;
         if (pending.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         for (int i = 0; i < 3; i++) begin
            if (got.pos[i] !== e.pos[i]) begin
               $error("pos_%s expected %h actual %h", axis[i], e.pos[i], got.pos[i]);
               errors++;
            end
            if (got.qv[i] !== e.qv[i]) begin
               $error("quat_%s expected %h actual %h", axis[i], e.qv[i], got.qv[i]);
               errors++;
            end
         end
         if (got.qw !== e.qw) begin
            $error("quat_w expected %h actual %h", e.qw, got.qw);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [17:0] req_r00 = 0, req_r01 = 0, req_r02 = 0;
   logic [17:0] req_r10 = 0, req_r11 = 0, req_r12 = 0;
   logic [17:0] req_r20 = 0, req_r21 = 0, req_r22 = 0;
   logic [31:0] req_tx = 0, req_ty = 0, req_tz = 0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [16:0] rsp_quat_w;
   logic [17:0] rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic csr_write = 0;
   logic [1:0] csr_index = pmq_pkg::CsrOffX;
   logic [20:0] csr_data = 0;

   pose_scoreboard board = new();
   int poses_sent = 0;
   bit stim_done = 0;

   always #1 clock = ~clock;

   pose_matrix_to_position_quaternion i_dut (.*);

   // No gap or a short one, now and then a long one; no gap in a busy phase
   function automatic int gap_length(bit busy_phase);
      int sel;
      sel = $urandom_range(0, 99);
      if (busy_phase || sel < 45) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one pose beat and hold it until it is taken; called just after an edge
   task automatic send_pose(pose_type p, bit busy_phase);
      int gap;
      gap = gap_length(busy_phase);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_r00, req_r01, req_r02} <= {p.r[0], p.r[1], p.r[2]};
      {req_r10, req_r11, req_r12} <= {p.r[3], p.r[4], p.r[5]};
      {req_r20, req_r21, req_r22} <= {p.r[6], p.r[7], p.r[8]};
      {req_tx, req_ty, req_tz} <= {p.t[0], p.t[1], p.t[2]};
      do @(posedge clock); while (req_stall);
      board.note_pose(p);
      poses_sent++;
   endtask

   // Wait until every outstanding result is back, then let the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_offset(logic [1:0] idx, logic [20:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      board.write_offset(idx, value);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [17:0] rand_rot();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 18'h20000 | 18'($urandom);  // wide negatives
      if (sel == 1) return 18'($urandom);              // any bit pattern
      if (sel == 2) return 18'(65536);
      if (sel == 3) return -18'sd65536;
      return 18'($signed($urandom_range(0, 131072)) - 65536);
   endfunction

   function automatic pose_type rand_pose();
      pose_type p;
      for (int i = 0; i < 9; i++) p.r[i] = rand_rot();
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 5))
            0: p.t[i] = 32'h7fffffff - $urandom_range(0, 100000);
            1: p.t[i] = 32'h80000000 + $urandom_range(0, 100000);
            2: p.t[i] = $urandom;
            default: p.t[i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
         endcase
      end
      // near-identity or pure axis rotations keep radicands interesting
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < 9; i++) p.r[i] = (i % 4 == 0) ? 18'(65536) : 18'd0;
         p.r[$urandom_range(0, 8)] = rand_rot();
      end
      return p;
   endfunction

   function automatic pose_type diag_pose(int a, int b, int c, int t);
      pose_type p;
      for (int i = 0; i < 9; i++) p.r[i] = 18'd0;
      p.r[0] = 18'(a);
      p.r[4] = 18'(b);
      p.r[8] = 18'(c);
      for (int i = 0; i < 3; i++) p.t[i] = 32'(t);
      return p;
   endfunction

   // Response side: random stalls or none by phase, compare each accepted beat
   initial begin
      pose_result_type got;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.pos = '{rsp_pos_x, rsp_pos_y, rsp_pos_z};
            got.qw = rsp_quat_w;
            got.qv = '{rsp_quat_x, rsp_quat_y, rsp_quat_z};
            board.check_result(got);
         end
         if (reset) rsp_stall <= 1'b1;
         else if (((poses_sent / 150) % 2) == 1) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(0, 99) < 30) ||
                           ($urandom_range(0, 199) == 0);
      end
   end

   initial begin
      pose_type p;
      logic [20:0] offsets [4];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: identity, 180 degree turns, clamped radicands, extremes
      send_pose(diag_pose(65536, 65536, 65536, 0), 0);
      send_pose(diag_pose(65536, -65536, -65536, 32'h7fffffff), 0);
      send_pose(diag_pose(-65536, 65536, -65536, 32'h80000000), 0);
      send_pose(diag_pose(-65536, -65536, 65536, 12345), 0);
      send_pose(diag_pose(-65536, -65536, -65536, -1), 0);
      send_pose(diag_pose(-131072, -131072, -131072, 0), 0);
      send_pose(diag_pose(131071, 131071, 131071, 0), 0);
      send_pose(diag_pose(0, 0, 0, 0), 0);
      p = diag_pose(0, 0, 0, 0);
      p.r[1] = 65536; p.r[3] = -65536; p.r[8] = 65536;  // negative z sign
      p.r[5] = 65536; p.r[7] = -65536;
      p.r[2] = -65536; p.r[6] = 65536;
      send_pose(p, 0);
      p.r = '{-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072};
      send_pose(p, 0);
      drain();

      // Position saturation with large offsets
      write_offset(pmq_pkg::CsrOffX, 21'h0fffff);
      write_offset(pmq_pkg::CsrOffY, 21'h100000);
      write_offset(pmq_pkg::CsrOffZ, 21'h0fffff);
      write_offset(2'd3, 21'h1abcde);  // unused index, must be ignored
      p = diag_pose(131071, -131072, 131071, 32'h7ffffff0);
      send_pose(p, 0);
      p = diag_pose(-131072, 131071, -131072, 32'h80000010);
      send_pose(p, 0);
      p.r = '{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071};
      send_pose(p, 0);
      for (int i = 0; i < 3; i++) p.t[i] = 32'h7fffffff;
      send_pose(p, 0);
      drain();

      offsets = '{21'd0, 21'h0fffff, 21'h100000, 21'h1fffff};
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 6) begin
            write_offset(pmq_pkg::CsrOffX, pmq_pkg::OffXReset);
            write_offset(pmq_pkg::CsrOffY, pmq_pkg::OffYReset);
            write_offset(pmq_pkg::CsrOffZ, pmq_pkg::OffZReset);
         end else if (phase < 2) begin
            write_offset(pmq_pkg::CsrOffX, offsets[$urandom_range(0, 3)]);
            write_offset(pmq_pkg::CsrOffY, offsets[$urandom_range(0, 3)]);
            write_offset(pmq_pkg::CsrOffZ, offsets[$urandom_range(0, 3)]);
         end else begin
            write_offset(pmq_pkg::CsrOffX, 21'($urandom));
            write_offset(pmq_pkg::CsrOffY, 21'($urandom));
            write_offset(pmq_pkg::CsrOffZ,
                         21'($signed($urandom_range(0, 40000)) - 20000));
         end
         for (int k = 0; k < 145; k++) send_pose(rand_pose(), (k / 40) % 2 == 1);
         drain();  // sender holds off until every result is back
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      $display("Sent %0d poses over several offset settings, checked %0d results.",
               poses_sent, board.checked);
      $display("Covered identity, axis turns, clamped roots, sign ties and saturation.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
